// ----- sv/lldf_pkg.sv -----
package lldf_pkg;

    localparam int LEVEL_W   = 3;
    localparam int BRIGHT_W  = 8;
    localparam int LVREG_W   = 9;
    localparam int TICK_W    = 16;
    localparam int TABLE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] LVL_OFF = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_DIM = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_MAX = 3'd4;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_INCREASE = 3'd1,
        REQ_DECREASE = 3'd2,
        REQ_TURN_ON  = 3'd3,
        REQ_TURN_OFF = 3'd4,
        REQ_SET      = 3'd5
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM      = 3'd0,
        CFG_MEDIUM   = 3'd1,
        CFG_BRIGHT   = 3'd2,
        CFG_MAX      = 3'd3,
        CFG_FALLBACK = 3'd4,
        CFG_FADE     = 3'd5,
        CFG_ILLUM    = 3'd6,
        CFG_INDIC    = 3'd7
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_request;
        logic prepare;
        logic multiply;
        logic div_step;
        logic load_result;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } t_status;

endpackage

// ----- sv/led_level_dimmer_with_fade_unit.sv -----
// Channel   Direction  Handshake                Payload
// in        request    i_in_valid / o_in_stall  i_req_type, i_allow_off, i_new_level
// out       result     o_out_valid/i_out_stall  o_level_now, o_faded_brightness,
//                                               o_illumination_out, o_indicator_out
// cfg       write      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request is taken in the idle state and then passes through prepare, multiply,
// the eight-step restoring divider by fade_ticks and done, where its result is
// loaded into the output register; a new request is accepted only after that.
// Reset is synchronous and active low; it restores the configuration, level and
// control registers and leaves the output register empty, without clearing data.
// A stalled result stays in the output register while the next request is
// already being processed; that request then waits in its last step.
module led_level_dimmer_with_fade_unit
    import lldf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_req_type,
    input  logic                 i_allow_off,
    input  logic [LEVEL_W-1:0]   i_new_level,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [LEVEL_W-1:0]   o_level_now,
    output logic [BRIGHT_W-1:0]  o_faded_brightness,
    output logic [BRIGHT_W-1:0]  o_illumination_out,
    output logic [BRIGHT_W-1:0]  o_indicator_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TABLE_W-1:0]   i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // The user is bound to make configuration writes only while the block is idle;
    // the block itself does not enforce this, and o_cfg_ready is tied high.
    assign o_cfg_ready = 1'b1;

    // The controller sequences one request at a time: take it, look up the
    // two brightness values, form the fade product, divide, then present.
    lldf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the level state, the configuration registers, the
    // multiplier, the divider and the output register.
    lldf_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_write        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_req_type         (i_req_type),
        .i_allow_off        (i_allow_off),
        .i_new_level        (i_new_level),
        .o_level_now        (o_level_now),
        .o_faded_brightness (o_faded_brightness),
        .o_illumination_out (o_illumination_out),
        .o_indicator_out    (o_indicator_out)
    );

endmodule

// ----- sv/lldf_datapath.sv -----
module lldf_datapath
    import lldf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_cfg_write,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TABLE_W-1:0]   i_cfg_data,
    input  logic [2:0]           i_req_type,
    input  logic                 i_allow_off,
    input  logic [LEVEL_W-1:0]   i_new_level,
    output logic [LEVEL_W-1:0]   o_level_now,
    output logic [BRIGHT_W-1:0]  o_faded_brightness,
    output logic [BRIGHT_W-1:0]  o_illumination_out,
    output logic [BRIGHT_W-1:0]  o_indicator_out
);

    logic [3:0][LVREG_W-1:0] r_lvreg;
    logic [BRIGHT_W-1:0]     r_fallback;
    logic [TICK_W-1:0]       r_fade;
    logic [TABLE_W-1:0]      r_illum;
    logic [TABLE_W-1:0]      r_indic;

    logic [LEVEL_W-1:0]      r_cur, r_prev;
    logic [TICK_W-1:0]       r_ticks;

    logic [BRIGHT_W-1:0]     r_p, r_c, r_diff;
    logic                    r_down, r_direct;
    logic [TICK_W-1:0]       r_rem;
    logic [BRIGHT_W-1:0]     r_lo;
    logic [STEP_W-1:0]       r_step;

    logic [LEVEL_W-1:0]      r_level_out;
    logic [BRIGHT_W-1:0]     r_fade_out, r_illum_out, r_indic_out;

    logic                    change;
    logic [LEVEL_W-1:0]      n_level;
    logic [BRIGHT_W-1:0]     p_bright, c_bright;
    logic [BRIGHT_W+TICK_W-1:0] product;
    logic [TICK_W:0]         trial;
    logic                    q_bit;
    logic [1:0]              tab_sel;
    logic [BRIGHT_W-1:0]     illum_byte, indic_byte, fade_val;

    // Brightness of a level: off is dark, otherwise the nearest set register
    // at or below the level, else the fallback.
    function automatic logic [BRIGHT_W-1:0] level_bright(
        input logic [LEVEL_W-1:0]      lvl,
        input logic [3:0][LVREG_W-1:0] regs,
        input logic [BRIGHT_W-1:0]     fallback
    );
        logic [BRIGHT_W-1:0] res;
        res = fallback;
        for (int i = 0; i < 4; i++) begin
            if ((LEVEL_W'(i) < lvl) && !regs[i][LVREG_W-1]) begin
                res = regs[i][BRIGHT_W-1:0];
            end
        end
        if (lvl == LVL_OFF || lvl > LVL_MAX) begin
            res = '0;
        end
        return res;
    endfunction

    always_comb begin
        change  = 1'b0;
        n_level = r_cur;
        unique case (t_req'(i_req_type))
            REQ_INCREASE: begin
                if (r_cur < LVL_MAX) begin
                    change  = 1'b1;
                    n_level = r_cur + LEVEL_W'(1);
                end
            end
            REQ_DECREASE: begin
                if (r_cur > LVL_DIM) begin
                    change  = 1'b1;
                    n_level = r_cur - LEVEL_W'(1);
                end else if (r_cur == LVL_DIM && i_allow_off) begin
                    change  = 1'b1;
                    n_level = LVL_OFF;
                end
            end
            REQ_TURN_ON: begin
                if (r_cur == LVL_OFF) begin
                    change  = 1'b1;
                    n_level = r_prev;
                end
            end
            REQ_TURN_OFF: begin
                if (r_cur != LVL_OFF) begin
                    change  = 1'b1;
                    n_level = LVL_OFF;
                end
            end
            REQ_SET: begin
                if (i_new_level <= LVL_MAX) begin
                    change  = 1'b1;
                    n_level = i_new_level;
                end
            end
            default: begin
                change  = 1'b0;
                n_level = r_cur;
            end
        endcase
    end

    assign p_bright = level_bright(r_prev, r_lvreg, r_fallback);
    assign c_bright = level_bright(r_cur, r_lvreg, r_fallback);
    assign product  = r_diff * r_ticks;
    assign trial    = {r_rem, r_lo[BRIGHT_W-1]};
    assign q_bit    = (trial >= {1'b0, r_fade});
    assign tab_sel  = 2'(r_cur - LEVEL_W'(1));

    always_comb begin
        illum_byte = r_illum[tab_sel*BRIGHT_W +: BRIGHT_W];
        indic_byte = r_indic[tab_sel*BRIGHT_W +: BRIGHT_W];
        if (r_cur == LVL_OFF || r_cur > LVL_MAX) begin
            illum_byte = '0;
            indic_byte = '0;
        end
        if (r_direct) begin
            fade_val = r_c;
        end else if (r_down) begin
            fade_val = r_p - r_lo;
        end else begin
            fade_val = r_p + r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvreg    <= {4{{LVREG_W{1'b1}}}};
            r_fallback <= BRIGHT_W'(128);
            r_fade     <= TICK_W'(100);
            r_illum    <= '0;
            r_indic    <= '0;
        end else if (i_cfg_write) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIM:      r_lvreg[0] <= i_cfg_data[LVREG_W-1:0];
                CFG_MEDIUM:   r_lvreg[1] <= i_cfg_data[LVREG_W-1:0];
                CFG_BRIGHT:   r_lvreg[2] <= i_cfg_data[LVREG_W-1:0];
                CFG_MAX:      r_lvreg[3] <= i_cfg_data[LVREG_W-1:0];
                CFG_FALLBACK: r_fallback <= i_cfg_data[BRIGHT_W-1:0];
                CFG_FADE:     r_fade     <= i_cfg_data[TICK_W-1:0];
                CFG_ILLUM:    r_illum    <= i_cfg_data;
                CFG_INDIC:    r_indic    <= i_cfg_data;
                default:      r_illum    <= r_illum;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= LVL_OFF;
            r_prev  <= LVL_OFF;
            r_ticks <= '0;
        end else if (i_cmd.take_request) begin
            if (change) begin
                r_prev  <= r_cur;
                r_cur   <= n_level;
                r_ticks <= '0;
            end else if (t_req'(i_req_type) == REQ_TICK && r_ticks < r_fade) begin
                r_ticks <= r_ticks + TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.multiply) begin
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prepare) begin
            r_p      <= p_bright;
            r_c      <= c_bright;
            r_down   <= (c_bright < p_bright);
            r_diff   <= (c_bright < p_bright) ? (p_bright - c_bright)
                                              : (c_bright - p_bright);
            r_direct <= (r_fade == '0) || (r_ticks >= r_fade);
        end
        if (i_cmd.multiply) begin
            // The quotient stays below 256, so the upper product bits start
            // out as the partial remainder.
            r_rem <= product[BRIGHT_W +: TICK_W];
            r_lo  <= product[BRIGHT_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? TICK_W'(trial - {1'b0, r_fade}) : trial[TICK_W-1:0];
            r_lo  <= {r_lo[BRIGHT_W-2:0], q_bit};
        end
        if (i_cmd.load_result) begin
            r_level_out <= r_cur;
            r_fade_out  <= fade_val;
            r_illum_out <= illum_byte;
            r_indic_out <= indic_byte;
        end
    end

    assign o_status.div_last  = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_level_now        = r_level_out;
    assign o_faded_brightness = r_fade_out;
    assign o_illumination_out = r_illum_out;
    assign o_indicator_out    = r_indic_out;

endmodule

// ----- sv/lldf_ctrl.sv -----
module lldf_ctrl
    import lldf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_request = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prepare = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.multiply = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- test/led_level_dimmer_with_fade_unit_tb.sv -----
`timescale 1ns / 1ps

module led_level_dimmer_with_fade_unit_tb;
    import lldf_pkg::*;

    // Clock, run length and pacing figures.
    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 16;    // output latency plus margin
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles without any handshake
    localparam int LONG_HOLD       = 400;   // receiver hold-off for the fill-up test
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int MAX_REPORTS     = 10;

    // Request codes that the block must ignore.
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    // Levels the package does not name, and an out-of-range level.
    localparam logic [LEVEL_W-1:0] LVL_MEDIUM  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_BRIGHT  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_INVALID = 3'd7;

    // A level register holding -1 in nine bits marks the level as unset.
    localparam logic [LVREG_W-1:0] LEVEL_UNSET = 9'h1FF;

    typedef struct {
        logic [LEVEL_W-1:0]  level;
        logic [BRIGHT_W-1:0] brightness;
        logic [BRIGHT_W-1:0] illumination;
        logic [BRIGHT_W-1:0] indicator;
    } t_dimmer_out;

    typedef enum {RX_FREE, RX_SPARSE, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    // The scoreboard carries its own copy of the dimmer's registers and state.
    // Each accepted request advances that copy and queues the result the block
    // has to produce; each accepted result is checked against the oldest entry.
    class dimmer_scoreboard;
        logic [LVREG_W-1:0]  level_reg [4];
        logic [BRIGHT_W-1:0] fallback;
        logic [TICK_W-1:0]   fade_ticks;
        logic [TABLE_W-1:0]  illum_table;
        logic [TABLE_W-1:0]  indic_table;
        logic [LEVEL_W-1:0]  level_now;
        logic [LEVEL_W-1:0]  level_before;
        logic [TICK_W-1:0]   ticks;
        t_dimmer_out         expected_outputs [$];
        int                  mismatches;

        function new();
            for (int i = 0; i < 4; i++)
                level_reg[i] = LEVEL_UNSET;
            fallback     = 8'd128;
            fade_ticks   = 16'd100;
            illum_table  = '0;
            indic_table  = '0;
            level_now    = LVL_OFF;
            level_before = LVL_OFF;
            ticks        = '0;
            mismatches   = 0;
        endfunction

        function void write_register(t_cfg_idx idx, logic [TABLE_W-1:0] data);
            case (idx)
                CFG_DIM:      level_reg[0] = data[LVREG_W-1:0];
                CFG_MEDIUM:   level_reg[1] = data[LVREG_W-1:0];
                CFG_BRIGHT:   level_reg[2] = data[LVREG_W-1:0];
                CFG_MAX:      level_reg[3] = data[LVREG_W-1:0];
                CFG_FALLBACK: fallback     = data[BRIGHT_W-1:0];
                CFG_FADE:     fade_ticks   = data[TICK_W-1:0];
                CFG_ILLUM:    illum_table  = data;
                CFG_INDIC:    indic_table  = data;
                default: ;
            endcase
        endfunction

        // An unset level borrows from the nearest set level below it.
        function logic [BRIGHT_W-1:0] level_brightness(logic [LEVEL_W-1:0] lvl);
            if (lvl == LVL_OFF || lvl > LVL_MAX)
                return '0;
            for (int i = int'(lvl); i >= 1; i--)
                if (!level_reg[i-1][LVREG_W-1])
                    return level_reg[i-1][BRIGHT_W-1:0];
            return fallback;
        endfunction

        function logic [BRIGHT_W-1:0] table_byte(logic [TABLE_W-1:0] byte_table,
                                                 logic [LEVEL_W-1:0] lvl);
            int unsigned shift;
            if (lvl == LVL_OFF || lvl > LVL_MAX)
                return '0;
            shift = 8 * (int'(lvl) - 1);
            return byte_table[shift +: 8];
        endfunction

        // Linear fade from the old level's brightness toward the new one; the
        // step is truncated, so the value lags on the side of the old level.
        function logic [BRIGHT_W-1:0] faded_brightness();
            int unsigned from_b, to_b, span, elapsed;
            from_b  = level_brightness(level_before);
            to_b    = level_brightness(level_now);
            span    = fade_ticks;
            elapsed = ticks;
            if (span == 0 || elapsed >= span)
                return BRIGHT_W'(to_b);
            if (to_b >= from_b)
                return BRIGHT_W'(from_b + (to_b - from_b) * elapsed / span);
            return BRIGHT_W'(from_b - (from_b - to_b) * elapsed / span);
        endfunction

        function void change_level(logic [LEVEL_W-1:0] lvl);
            level_before = level_now;
            level_now    = lvl;
            ticks        = '0;
        endfunction

        function void note_request(logic [2:0] rt, logic ao, logic [LEVEL_W-1:0] nl);
            t_dimmer_out want;
            case (rt)
                REQ_TICK:     if (ticks < fade_ticks) ticks++;
                REQ_INCREASE: if (level_now < LVL_MAX) change_level(level_now + 1'b1);
                REQ_DECREASE: begin
                    if (level_now > LVL_DIM)
                        change_level(level_now - 1'b1);
                    else if (level_now == LVL_DIM && ao)
                        change_level(LVL_OFF);
                end
                REQ_TURN_ON:  if (level_now == LVL_OFF) change_level(level_before);
                REQ_TURN_OFF: if (level_now != LVL_OFF) change_level(LVL_OFF);
                REQ_SET:      if (nl <= LVL_MAX) change_level(nl);
                default: ;
            endcase
            want.level        = level_now;
            want.brightness   = faded_brightness();
            want.illumination = table_byte(illum_table, level_now);
            want.indicator    = table_byte(indic_table, level_now);
            expected_outputs.push_back(want);
        endfunction

        function void check_output(logic [LEVEL_W-1:0] lvl, logic [BRIGHT_W-1:0] br,
                                   logic [BRIGHT_W-1:0] il, logic [BRIGHT_W-1:0] ind);
            t_dimmer_out want;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR %0t: result with no request pending: level %0d bright %0d",
                             $realtime, lvl, br);
                return;
            end
            want = expected_outputs.pop_front();
            if (want.level !== lvl || want.brightness !== br ||
                    want.illumination !== il || want.indicator !== ind) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR %0t: expected level %0d bright %0d illum %0d indic %0d",
                             $realtime, want.level, want.brightness, want.illumination,
                             want.indicator);
                    $display("           got      level %0d bright %0d illum %0d indic %0d",
                             lvl, br, il, ind);
                end
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic [2:0]           req_type    = REQ_TICK;
    logic                 allow_off   = 1'b0;
    logic [LEVEL_W-1:0]   new_level   = LVL_OFF;
    logic                 out_stall   = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_DIM;
    logic [TABLE_W-1:0]   cfg_data    = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [LEVEL_W-1:0]   o_level_now;
    logic [BRIGHT_W-1:0]  o_faded_brightness;
    logic [BRIGHT_W-1:0]  o_illumination_out;
    logic [BRIGHT_W-1:0]  o_indicator_out;
    logic                 o_cfg_ready;

    dimmer_scoreboard sb = new();

    // Sender pacing: requests go out in bursts; between bursts the valid line
    // drops for a random number of cycles when gaps are enabled for the phase.
    int burst_left    = 0;
    bit gaps_enabled  = 1'b1;
    // Each increment asks the receiver for one long hold-off.
    int hold_requests = 0;

    led_level_dimmer_with_fade_unit i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (req_type),
        .i_allow_off        (allow_off),
        .i_new_level        (new_level),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_level_now        (o_level_now),
        .o_faded_brightness (o_faded_brightness),
        .o_illumination_out (o_illumination_out),
        .o_indicator_out    (o_indicator_out),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Handshakes are observed at the rising edge, where the testbench inputs
    // have been stable since the previous falling edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall)
                sb.note_request(req_type, allow_off, new_level);
            if (o_out_valid && !out_stall)
                sb.check_output(o_level_now, o_faded_brightness, o_illumination_out,
                                o_indicator_out);
        end
    end

    // The watchdog restarts its count on any handshake on any channel, so it
    // only trips when the block has stopped making progress.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                    (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // The receiver switches between stall patterns of its own, each held for a random
    // segment. When a long hold-off is asked for, it first keeps the stall high over
    // the LONG_HOLD hold-off so that the block fills up and has to stall its input.
    initial begin : receiver
        int unsigned segment, beat, holds_served;
        t_rx_mode    mode;
        holds_served = 0;
        beat         = 0;
        forever begin
            if (holds_served < hold_requests) begin
                holds_served++;
                @(negedge clk);
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            mode    = t_rx_mode'($urandom_range(0, 3));
            segment = $urandom_range(10, 150);
            repeat (segment) begin
                @(negedge clk);
                beat++;
                case (mode)
                    RX_FREE:     out_stall = 1'b0;
                    RX_SPARSE:   out_stall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    out_stall = ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: out_stall = ((beat % 7) < 3);
                    default:     out_stall = 1'b0;
                endcase
            end
        end
    end

    // Offers one request and returns at the edge where it is accepted. Valid
    // stays high into the next request of a burst; the payload only changes
    // after acceptance.
    task automatic send_request(logic [2:0] rt, logic ao, logic [LEVEL_W-1:0] nl);
        if (burst_left == 0) begin
            if (gaps_enabled) begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat ($urandom_range(0, 24)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid  = 1'b1;
        req_type  = rt;
        allow_off = ao;
        new_level = nl;
        do @(posedge clk); while (o_in_stall);
    endtask

    // Weighted mix of requests. Level changes and ticks dominate; the two
    // unused codes and out-of-range levels appear now and then as noise.
    task automatic send_random_request();
        int unsigned        roll;
        logic [2:0]         rt;
        logic [LEVEL_W-1:0] nl;
        roll = $urandom_range(0, 99);
        if (roll < 35)       rt = REQ_TICK;
        else if (roll < 52)  rt = REQ_INCREASE;
        else if (roll < 69)  rt = REQ_DECREASE;
        else if (roll < 77)  rt = REQ_TURN_ON;
        else if (roll < 85)  rt = REQ_TURN_OFF;
        else if (roll < 97)  rt = REQ_SET;
        else if (roll < 98)  rt = REQ_UNUSED_LO;
        else                 rt = REQ_UNUSED_HI;
        if ($urandom_range(0, 7) == 0)
            nl = LEVEL_W'($urandom_range(int'(LVL_MAX) + 1, int'(LVL_INVALID)));
        else
            nl = LEVEL_W'($urandom_range(int'(LVL_OFF), int'(LVL_MAX)));
        send_request(rt, 1'($urandom), nl);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [TABLE_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_settings(logic [LVREG_W-1:0] dim, logic [LVREG_W-1:0] mid,
                                 logic [LVREG_W-1:0] bright, logic [LVREG_W-1:0] top,
                                 logic [BRIGHT_W-1:0] fb, logic [TICK_W-1:0] fade,
                                 logic [TABLE_W-1:0] illum, logic [TABLE_W-1:0] indic);
        write_register(CFG_DIM,      TABLE_W'(dim));
        write_register(CFG_MEDIUM,   TABLE_W'(mid));
        write_register(CFG_BRIGHT,   TABLE_W'(bright));
        write_register(CFG_MAX,      TABLE_W'(top));
        write_register(CFG_FALLBACK, TABLE_W'(fb));
        write_register(CFG_FADE,     TABLE_W'(fade));
        write_register(CFG_ILLUM,    illum);
        write_register(CFG_INDIC,    indic);
    endtask

    // Level registers lean toward the interesting values: unset, zero, full.
    function automatic logic [LVREG_W-1:0] pick_level_value();
        case ($urandom_range(0, 4))
            0:       return LEVEL_UNSET;
            1:       return '0;
            2:       return 9'd255;
            default: return LVREG_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Short fades mostly, so that ticks reach the end of the fade often.
    function automatic logic [TICK_W-1:0] pick_fade();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return TICK_W'($urandom);
            default: return TICK_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [TABLE_W-1:0] pick_table();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Registers may only change while the block is idle: stop offering
    // requests, wait for every outstanding result, then let the pipeline settle.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int items_left, run;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: every level is unset, so everything falls back.
        // Turning on from off with the remembered level also off still counts
        // as a level change.
        send_request(REQ_TICK, 1'b0, LVL_OFF);
        send_request(REQ_TURN_ON, 1'b0, LVL_OFF);
        drain();

        // Medium is unset and borrows from dim; the fade is four ticks long.
        load_settings(9'd40, LEVEL_UNSET, 9'd255, 9'd0, 8'd200, 16'd4,
                      32'h1122_3344, 32'hFFEE_DDCC);
        repeat (5) send_request(REQ_INCREASE, 1'b0, LVL_OFF);  // the last one sits at max
        repeat (5) send_request(REQ_TICK, 1'b0, LVL_OFF);      // the count stops at the fade
        repeat (3) send_request(REQ_DECREASE, 1'b1, LVL_OFF);
        send_request(REQ_DECREASE, 1'b0, LVL_OFF);   // dim holds without allow_off
        send_request(REQ_DECREASE, 1'b1, LVL_OFF);   // dim steps down to off
        send_request(REQ_DECREASE, 1'b1, LVL_OFF);   // nothing below off
        send_request(REQ_TURN_OFF, 1'b0, LVL_OFF);   // already off
        send_request(REQ_TURN_ON, 1'b0, LVL_OFF);    // back to the remembered level
        send_request(REQ_TURN_ON, 1'b0, LVL_OFF);    // already on
        send_request(REQ_SET, 1'b0, LVL_MAX);
        send_request(REQ_SET, 1'b0, LVL_MAX);        // same level still restarts the fade
        send_request(REQ_SET, 1'b0, LVL_INVALID);    // out of range, ignored
        send_request(REQ_UNUSED_LO, 1'b1, LVL_BRIGHT);
        send_request(REQ_UNUSED_HI, 1'b1, LVL_MEDIUM);
        drain();

        // A zero-length fade is always complete and the count stays at zero.
        load_settings(9'd255, 9'd0, LEVEL_UNSET, 9'd128, 8'd0, 16'd0, '1, '0);
        send_request(REQ_SET, 1'b0, LVL_MEDIUM);
        send_request(REQ_TICK, 1'b0, LVL_OFF);
        drain();

        // Shortening the fade below the elapsed count completes the fade and
        // freezes the count.
        write_register(CFG_FADE, TABLE_W'(16'd50));
        send_request(REQ_SET, 1'b0, LVL_DIM);
        repeat (4) send_request(REQ_TICK, 1'b0, LVL_OFF);
        drain();
        write_register(CFG_FADE, TABLE_W'(16'd3));
        repeat (2) send_request(REQ_TICK, 1'b0, LVL_OFF);
        drain();

        // Random phases. Phase 1 and 2 pin the register extremes, phase 3 runs
        // without sender gaps while the receiver holds off for a long stretch.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 1)
                load_settings(9'd255, 9'd255, 9'd255, 9'd255, 8'd255, 16'hFFFF, '1, '1);
            else if (phase == 2)
                load_settings('0, '0, '0, '0, '0, 16'd1, '0, '0);
            else
                load_settings(pick_level_value(), pick_level_value(), pick_level_value(),
                              pick_level_value(), BRIGHT_W'($urandom), pick_fade(),
                              pick_table(), pick_table());
            gaps_enabled = (phase % 3 != 0);
            if (phase == 3)
                hold_requests++;
            items_left = ITEMS_PER_PHASE;
            while (items_left > 0) begin
                // Runs of ticks let fades progress and reach their end.
                if ($urandom_range(0, 2) == 0) begin
                    run = $urandom_range(1, 16);
                    repeat (run)
                        send_request(REQ_TICK, 1'($urandom), LEVEL_W'($urandom));
                    items_left -= run;
                end else begin
                    send_random_request();
                    items_left--;
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
